FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// Uses the clk and rst names of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(label, prop)
`define ASSERT_NEVER(label, cond)
`endif
`endif

FILE: rtl/lcwf_pkg.sv
// Shared types and constants of the load cell weight filter.
// No dependencies.
package lcwf_pkg;

  localparam int BURST_LEN_DEF = 15;
  localparam int AVG_LEN_DEF   = 10;
  localparam int SW            = 24;
  localparam int WW            = 32;
  localparam int DIV_NW        = 38;
  localparam int DIV_DW        = 25;
  localparam int CFG_IW        = 3;
  localparam int CFG_DW        = 24;
  localparam int QDEPTH        = 4;

  typedef enum logic [CFG_IW-1:0] {
    REG_TARE   = 3'd0,
    REG_CPK    = 3'd1,
    REG_PCT    = 3'd2,
    REG_WINDOW = 3'd3,
    REG_NEEDED = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 ok;
    logic                 last;
  } entry_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIV_NW-1:0] num;
    logic signed [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [DIV_NW:0] quo;
  } div_rsp_t;

endpackage

FILE: rtl/lcwf_div.sv
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on lcwf_pkg.
module lcwf_div (
  input  logic              clk,
  input  logic              rst,
  input  lcwf_pkg::div_req_t req,
  output lcwf_pkg::div_rsp_t rsp
);
  localparam int NW = lcwf_pkg::DIV_NW;
  localparam int DW = lcwf_pkg::DIV_DW;
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] dmag;
  logic [NW-1:0] quo;
  logic          neg;
  logic [NW-1:0] num_mag;
  logic [DW-1:0] den_mag;
  logic [DW:0]   sh;
  logic [DW:0]   trial;

  assign num_mag = req.num[NW-1] ? NW'(-req.num) : NW'(req.num);
  assign den_mag = req.den[DW-1] ? DW'(-req.den) : DW'(req.den);
  assign sh      = {rem, quo[NW-1]};
  assign trial   = sh - {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        rem  <= '0;
        quo  <= num_mag;
        dmag <= den_mag;
        neg  <= req.num[NW-1] ^ req.den[DW-1];
      end else if (busy) begin
        if (!trial[DW]) begin
          rem <= trial[DW-1:0];
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= sh[DW-1:0];
          quo <= {quo[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
endmodule

FILE: rtl/lcwf_front.sv
// Input side: accepts items, drops invalid non-final samples, queues the rest.
// Depends on lcwf_pkg.
module lcwf_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [lcwf_pkg::SW-1:0]  sample,
  input  logic                            sample_ok,
  input  logic                            burst_end,
  output logic                            q_valid,
  output lcwf_pkg::entry_t                q_entry,
  input  logic                            q_pop
);
  localparam int AW = $clog2(lcwf_pkg::QDEPTH);
  localparam int CW = $clog2(lcwf_pkg::QDEPTH + 1);

  lcwf_pkg::entry_t mem [lcwf_pkg::QDEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign in_stall = (count == CW'(lcwf_pkg::QDEPTH));
  assign push     = in_valid && !in_stall && (sample_ok || burst_end);
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{sample: sample, ok: sample_ok, last: burst_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(lcwf_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(lcwf_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end
endmodule

FILE: rtl/lcwf_back.sv
// Burst processing: sorted sample store, median outlier rejection, scaling,
// ring moving average and stability tracking. Depends on lcwf_pkg.
module lcwf_back #(
  parameter int BURST_LEN = lcwf_pkg::BURST_LEN_DEF,
  parameter int AVG_LEN   = lcwf_pkg::AVG_LEN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [lcwf_pkg::CFG_IW-1:0]          cfg_index,
  input  logic [lcwf_pkg::CFG_DW-1:0]          cfg_data,
  input  logic                                 q_valid,
  input  lcwf_pkg::entry_t                     q_entry,
  output logic                                 q_pop,
  output lcwf_pkg::div_req_t                   div_req,
  input  lcwf_pkg::div_rsp_t                   div_rsp,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic signed [lcwf_pkg::WW-1:0]       weight_grams,
  output logic                                 steady,
  output logic                                 status,
  output logic [3:0]                           outliers_dropped
);
  localparam int SW   = lcwf_pkg::SW;
  localparam int WW   = lcwf_pkg::WW;
  localparam int NW   = lcwf_pkg::DIV_NW;
  localparam int DW   = lcwf_pkg::DIV_DW;
  localparam int CW   = $clog2(BURST_LEN + 1);
  localparam int IW   = $clog2(BURST_LEN);
  localparam int PW   = $clog2(AVG_LEN);
  localparam int FW   = $clog2(AVG_LEN + 1);
  localparam int TW   = WW + FW;
  localparam int SUMW = SW + CW;
  localparam logic signed [NW:0] Q_MAX = (NW + 1)'(64'sd2147483647);
  localparam logic signed [NW:0] Q_MIN = -Q_MAX - 1;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_CHECK = 14'b00000000000010,
    S_MED   = 14'b00000000000100,
    S_PROD  = 14'b00000000001000,
    S_SWEEP = 14'b00000000010000,
    S_SEL   = 14'b00000000100000,
    S_DIV1  = 14'b00000001000000,
    S_MUL   = 14'b00000010000000,
    S_SCALE = 14'b00000100000000,
    S_DIV2  = 14'b00001000000000,
    S_RING  = 14'b00010000000000,
    S_DIV3  = 14'b00100000000000,
    S_STAB  = 14'b01000000000000,
    S_EMIT  = 14'b10000000000000
  } state_t;

  state_t state;

  logic signed [SW-1:0] tare;
  logic signed [SW-1:0] cpk;
  logic [6:0]           pct;
  logic [15:0]          window;
  logic [7:0]           needed;

  logic signed [SW-1:0] sorted [BURST_LEN];
  logic signed [SW-1:0] ins_val [BURST_LEN];
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        cnt_next;
  logic [CW-1:0]        n;
  logic                 do_ins;
  logic [IW-1:0]        rd_idx;
  logic signed [SW-1:0] rd_val;

  logic signed [SW-1:0] med;
  logic [30:0]          prod;
  logic signed [SUMW-1:0] sum_all;
  logic signed [SUMW-1:0] sum_kept;
  logic [CW-1:0]        kept;
  logic signed [SW:0]   dev;
  logic [SW:0]          dev_mag;
  logic [31:0]          dev100;
  logic                 keep;
  logic                 use_all;
  logic [CW-1:0]        n_drop;

  logic signed [SW-1:0] mean;
  logic signed [NW-1:0] scaled_num;
  logic signed [SW:0]   diff;
  logic signed [NW-1:0] diff_x;
  logic signed [WW-1:0] grams;

  logic signed [WW-1:0] ring [AVG_LEN];
  logic [PW-1:0]        pos;
  logic [FW-1:0]        fill;
  logic [FW-1:0]        fill_next;
  logic signed [TW-1:0] total;
  logic signed [TW-1:0] total_next;
  logic                 ring_full;

  logic signed [WW-1:0] avg_new;
  logic signed [WW-1:0] avg_cur;
  logic signed [WW:0]   ddev;
  logic [WW:0]          ddev_mag;
  logic [7:0]           run;
  logic [7:0]           run_next;
  logic signed [WW-1:0] anchor;
  logic                 flag;
  logic                 res_status;
  logic [3:0]           res_drop;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign do_ins   = q_pop && q_entry.ok && (cnt < CW'(BURST_LEN));
  assign cnt_next = cnt + CW'(do_ins);
  assign rd_val   = sorted[rd_idx];

  always_comb begin
    logic                 g;
    logic                 prev_g;
    logic signed [SW-1:0] prev_v;
    prev_g = 1'b0;
    prev_v = q_entry.sample;
    for (int k = 0; k < BURST_LEN; k++) begin
      g = (CW'(k) >= cnt) || (sorted[k] > q_entry.sample);
      ins_val[k] = g ? (prev_g ? prev_v : q_entry.sample) : sorted[k];
      prev_g = g;
      prev_v = sorted[k];
    end
  end

  assign dev     = (SW + 1)'(rd_val) - (SW + 1)'(med);
  assign dev_mag = dev[SW] ? (SW + 1)'(-dev) : (SW + 1)'(dev);
  assign dev100  = (32'(dev_mag) << 6) + (32'(dev_mag) << 5) + (32'(dev_mag) << 2);
  assign keep    = dev100 <= {1'b0, prod};
  assign use_all = (n < CW'(3)) || (kept < (n >> 1));
  assign n_drop  = n - kept;

  assign diff   = (SW + 1)'(mean) - (SW + 1)'(tare);
  assign diff_x = NW'(diff);

  assign ring_full  = (fill >= FW'(AVG_LEN));
  assign fill_next  = ring_full ? fill : fill + 1'b1;
  assign total_next = total - (ring_full ? TW'(ring[pos]) : '0) + TW'(grams);

  assign avg_new  = div_rsp.quo[WW-1:0];
  assign ddev     = (WW + 1)'(avg_new) - (WW + 1)'(anchor);
  assign ddev_mag = ddev[WW] ? (WW + 1)'(-ddev) : (WW + 1)'(ddev);
  assign run_next = (ddev_mag < (WW + 1)'(window)) ? ((run == 8'd255) ? run : run + 1'b1)
                                                    : 8'd0;

  always_comb begin
    div_req = '0;
    case (state)
      S_SEL: begin
        div_req.start = 1'b1;
        div_req.num   = use_all ? NW'(sum_all) : NW'(sum_kept);
        div_req.den   = use_all ? DW'(n) : DW'(kept);
      end
      S_SCALE: begin
        div_req.start = 1'b1;
        div_req.num   = scaled_num;
        div_req.den   = (cpk == '0) ? DW'(1) : DW'(cpk);
      end
      S_RING: begin
        div_req.start = 1'b1;
        div_req.num   = NW'(total_next);
        div_req.den   = DW'(fill_next);
      end
      default: div_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_ins) begin
      for (int k = 0; k < BURST_LEN; k++) begin
        sorted[k] <= ins_val[k];
      end
    end
    if (state == S_RING) begin
      ring[pos] <= grams;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tare      <= '0;
      cpk       <= SW'(1000);
      pct       <= 7'd10;
      window    <= 16'd100;
      needed    <= 8'd5;
      cnt       <= '0;
      pos       <= '0;
      fill      <= '0;
      total     <= '0;
      run       <= '0;
      anchor    <= '0;
      flag      <= 1'b0;
      avg_cur   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          lcwf_pkg::REG_TARE:   tare   <= cfg_data[SW-1:0];
          lcwf_pkg::REG_CPK:    cpk    <= cfg_data[SW-1:0];
          lcwf_pkg::REG_PCT:    pct    <= cfg_data[6:0];
          lcwf_pkg::REG_WINDOW: window <= cfg_data[15:0];
          lcwf_pkg::REG_NEEDED: needed <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (q_entry.last) begin
              n     <= cnt_next;
              cnt   <= '0;
              state <= S_CHECK;
            end else begin
              cnt <= cnt_next;
            end
          end
        end
        S_CHECK: begin
          if (n < CW'(BURST_LEN / 2)) begin
            res_status <= 1'b1;
            res_drop   <= 4'd0;
            state      <= S_EMIT;
          end else begin
            rd_idx <= IW'(n >> 1);
            state  <= S_MED;
          end
        end
        S_MED: begin
          med      <= rd_val;
          rd_idx   <= '0;
          sum_all  <= '0;
          sum_kept <= '0;
          kept     <= '0;
          state    <= S_PROD;
        end
        S_PROD: begin
          prod  <= 31'(med[SW-1] ? -(SW + 1)'(med) : (SW + 1)'(med)) * 31'(pct);
          state <= S_SWEEP;
        end
        S_SWEEP: begin
          sum_all <= sum_all + SUMW'(rd_val);
          if (keep) begin
            sum_kept <= sum_kept + SUMW'(rd_val);
            kept     <= kept + 1'b1;
          end
          rd_idx <= rd_idx + 1'b1;
          if (CW'(rd_idx) + 1'b1 == n) begin
            state <= S_SEL;
          end
        end
        S_SEL: begin
          res_status <= 1'b0;
          if (use_all) begin
            res_drop <= 4'd0;
          end else begin
            res_drop <= (n_drop > CW'(15)) ? 4'd15 : 4'(n_drop);
          end
          state <= S_DIV1;
        end
        S_DIV1: begin
          if (div_rsp.done) begin
            mean  <= div_rsp.quo[SW-1:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          scaled_num <= (diff_x <<< 10) - (diff_x <<< 4) - (diff_x <<< 3);
          state      <= S_SCALE;
        end
        S_SCALE: begin
          state <= S_DIV2;
        end
        S_DIV2: begin
          if (div_rsp.done) begin
            if (div_rsp.quo > Q_MAX) begin
              grams <= Q_MAX[WW-1:0];
            end else if (div_rsp.quo < Q_MIN) begin
              grams <= Q_MIN[WW-1:0];
            end else begin
              grams <= div_rsp.quo[WW-1:0];
            end
            state <= S_RING;
          end
        end
        S_RING: begin
          total <= total_next;
          fill  <= fill_next;
          pos   <= (pos == PW'(AVG_LEN - 1)) ? '0 : pos + 1'b1;
          state <= S_DIV3;
        end
        S_DIV3: begin
          if (div_rsp.done) begin
            avg_cur <= avg_new;
            if (fill >= FW'(AVG_LEN / 2)) begin
              run  <= run_next;
              flag <= (run_next >= needed);
              if (ddev_mag >= (WW + 1)'(window)) begin
                anchor <= avg_new;
              end
            end
            state <= S_STAB;
          end
        end
        S_STAB: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid        <= 1'b1;
            weight_grams     <= avg_cur;
            steady           <= flag;
            status           <= res_status;
            outliers_dropped <= res_drop;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/load_cell_weight_filter_unit.sv
// Top level of the load cell weight filter: front queue, burst engine, divider.
// Depends on lcwf_pkg, lcwf_front, lcwf_back, lcwf_div and assert_macros.svh.
//
// Samples enter one per cycle, while the queue is not full, into a four-entry
// queue; the back end takes plain samples in while it is idle. The final sample
// of a burst with n valid samples starts a sweep over the n samples, bookkeeping
// steps and three passes of the shared radix-2 divider (mean, gram scaling,
// moving average), after which one result is offered; a too-few burst answers
// without the sweep or the divider. Only bursts that end produce a result;
// invalid samples inside a burst are dropped at the input.
module load_cell_weight_filter_unit #(
  parameter int BURST_LEN = lcwf_pkg::BURST_LEN_DEF,
  parameter int AVG_LEN   = lcwf_pkg::AVG_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [lcwf_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [lcwf_pkg::CFG_DW-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [lcwf_pkg::SW-1:0]      sample,
  input  logic                                sample_ok,
  input  logic                                burst_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lcwf_pkg::WW-1:0]      weight_grams,
  output logic                                steady,
  output logic                                status,
  output logic [3:0]                          outliers_dropped
);
  `include "assert_macros.svh"

  logic               q_valid;
  logic               q_pop;
  lcwf_pkg::entry_t   q_entry;
  lcwf_pkg::div_req_t div_req;
  lcwf_pkg::div_rsp_t div_rsp;

  lcwf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .sample_ok (sample_ok),
    .burst_end (burst_end),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop)
  );

  lcwf_back #(
    .BURST_LEN (BURST_LEN),
    .AVG_LEN   (AVG_LEN)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q_valid          (q_valid),
    .q_entry          (q_entry),
    .q_pop            (q_pop),
    .div_req          (div_req),
    .div_rsp          (div_rsp),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .weight_grams     (weight_grams),
    .steady           (steady),
    .status           (status),
    .outliers_dropped (outliers_dropped)
  );

  lcwf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  `ASSERT_PROP(a_err_no_drop, out_valid && status |-> outliers_dropped == 4'd0)
  `ASSERT_NEVER(a_pop_empty, q_pop && !q_valid)
  `ASSERT_PROP(a_quiet_after_reset, $past(rst) |-> !out_valid)
endmodule
